// ===== hdl/red_queue_drop_decider_defines.svh =====
// assertion macros for the red queue drop decider
`ifndef RED_QUEUE_DROP_DECIDER_DEFINES_SVH
`define RED_QUEUE_DROP_DECIDER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication or invariant
`define RQDD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rqdd assertion failed");
// condition now implies result in the next cycle
`define RQDD_ASSERT_NEXT(lbl, clk, rst, cond, nxt) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("rqdd assertion failed");
`else
`define RQDD_ASSERT(lbl, clk, rst, prop)
`define RQDD_ASSERT_NEXT(lbl, clk, rst, cond, nxt)
`endif

`endif

// ===== hdl/rqdd_pkg.sv =====
// shared types and constants for the red queue drop decider
package rqdd_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int TBL_AW      = $clog2(TABLE_DEPTH);

   localparam logic [15:0] MAXCOUNT_MAX = 16'hFFFF;
   localparam logic [31:0] LFSR_RESET   = 32'h2AABAAAB;
   localparam logic [15:0] RANDOM_RESET = 16'h8000;
   localparam logic [23:0] BYTE_MAX     = 24'hFFFFFF;
   localparam logic [21:0] AVG_MAX      = 22'h3FFFFF;
   localparam logic [15:0] SINCE_MAX    = 16'hFFFF;
   localparam logic [15:0] EARLY_MIN    = 16'd3;

   // operation codes
   localparam logic [2:0] OP_ARRIVAL     = 3'd0;
   localparam logic [2:0] OP_DEPARTURE   = 3'd1;
   localparam logic [2:0] OP_AVG_TICK    = 3'd2;
   localparam logic [2:0] OP_LFSR_TICK   = 3'd3;
   localparam logic [2:0] OP_TABLE_WRITE = 3'd4;

   // register indexes, byte address is 4 * index
   localparam int CSR_AW = 5;
   localparam logic [2:0] CSR_RED_ENABLE    = 3'd0;
   localparam logic [2:0] CSR_MIN_THRESHOLD = 3'd1;
   localparam logic [2:0] CSR_AVG_WEIGHT    = 3'd2;
   localparam logic [2:0] CSR_PACKET_LIMIT  = 3'd3;
   localparam logic [2:0] CSR_BYTE_LIMIT    = 3'd4;

   localparam logic        RST_RED_ENABLE    = 1'b1;
   localparam logic [5:0]  RST_MIN_THRESHOLD = 6'd5;
   localparam logic [15:0] RST_AVG_WEIGHT    = 16'd131;
   localparam logic [5:0]  RST_PACKET_LIMIT  = 6'd63;
   localparam logic [23:0] RST_BYTE_LIMIT    = 24'd96000;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] packet_length;
      logic [5:0]  table_index;
      logic [4:0]  table_shift;
   } req_type;

   typedef struct packed {
      logic        drop;
      logic        forced;
      logic        empty_error;
      logic [6:0]  queue_packets;
      logic [23:0] queue_bytes;
      logic [15:0] max_count;
      logic [31:0] drop_total;
      logic [31:0] forced_total;
      logic [31:0] arrival_total;
      logic [31:0] sent_total;
   } rsp_type;

   typedef struct packed {
      logic        red_enable;
      logic [5:0]  min_threshold;
      logic [15:0] avg_weight;
      logic [5:0]  packet_limit;
      logic [23:0] byte_limit;
   } cfg_type;

endpackage

// ===== hdl/red_queue_drop_decider.sv =====
// red queue drop decider: queue counters, average, lfsr, shift table and result buffer
//
// Requests arrive on req_valid/req_stall/req_data, one operation per transfer:
// arrival, departure, averaging tick, lfsr tick or shift-table write. Each
// request gives exactly one result on rsp_valid/rsp_stall/rsp_data, in order.
// Registers must be written through the csr_ apb-style port (no wait states)
// by the user only while the block is idle; the block does not enforce it.
//
// A result is registered in the output register, or the skid register if
// the output is held; for an averaging tick it follows the registered read
// of the shift-table memory. Throughput: one request per cycle while
// req_stall is low; an averaging tick holds req_stall during that read.
//
// A two-entry result buffer (output register plus skid register) lets a new
// request in while a result waits; req_stall rises only when both are full
// or a tick is resolving. Reset (synchronous) clears counters, average and
// statistics, loads the lfsr and thresholds and empties the result buffer.
// The shift table is not cleared and must be loaded before use.
`include "red_queue_drop_decider_defines.svh"

module red_queue_drop_decider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  rqdd_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rqdd_pkg::rsp_type           rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rqdd_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import rqdd_pkg::*;

   cfg_type cfg;

   rqdd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // state
   logic [31:0] lfsr_ff, lfsr_in;
   logic [15:0] rnd_ff, rnd_in;
   logic [21:0] avg_ff, avg_in;
   logic [15:0] since_ff, since_in;
   logic [15:0] thr_ff, thr_in;
   logic [6:0]  pkt_cnt_ff, pkt_cnt_in;
   logic [23:0] byte_cnt_ff, byte_cnt_in;
   logic [31:0] drops_ff, drops_in;
   logic [31:0] forced_ff, forced_in;
   logic [31:0] arrivals_ff, arrivals_in;
   logic [31:0] sent_ff, sent_in;
   logic        resolve_ff, resolve_in;
   logic        use_table_ff, use_table_in;

   // shift table memory
   logic [4:0]        tbl_mem [TABLE_DEPTH];
   logic [4:0]        tbl_rdata_ff;
   logic [TBL_AW-1:0] tbl_raddr;
   logic              tbl_wr_en;
   logic              tbl_rd_en;

   // result buffer
   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_data_ff, skid_data_ff;
   logic    rsp_pop;
   logic    push_valid;
   rsp_type push_data;

   logic       req_accept;
   logic       tick_accept;
   logic [2:0] op;

   // averaging datapath
   logic signed [24:0] avg_diff;
   logic signed [41:0] avg_prod;
   logic signed [25:0] avg_delta;
   logic signed [26:0] avg_sum;
   logic [21:0]        avg_new;
   logic [5:0]         avg_bin;
   logic [47:0]        thr_shifted;
   logic [15:0]        table_thr;

   // arrival datapath
   logic [15:0] since_inc;
   logic        red_kill, force_kill, kill;
   logic [24:0] byte_sum;
   logic        drop_flag, forced_flag, empty_flag;

   assign op          = req_data.operation;
   assign req_stall   = skid_valid_ff || resolve_ff;
   assign req_accept  = req_valid && !req_stall;
   assign tick_accept = req_accept && (op == OP_AVG_TICK);
   assign rsp_pop     = out_valid_ff && !rsp_stall;
   assign rsp_valid   = out_valid_ff;
   assign rsp_data    = out_data_ff;

   // avg + w * ((pkt << 16) - avg) / 65536, floor, equals the weighted sum form
   assign avg_diff  = $signed({2'b00, pkt_cnt_ff, 16'h0000}) - $signed({3'b000, avg_ff});
   assign avg_prod  = $signed({1'b0, cfg.avg_weight}) * avg_diff;
   assign avg_delta = 26'(avg_prod >>> 16);
   assign avg_sum   = $signed({5'b00000, avg_ff}) + $signed({avg_delta[25], avg_delta});
   assign avg_new   = (avg_sum > $signed({5'b00000, AVG_MAX})) ? AVG_MAX : avg_sum[21:0];
   assign avg_bin   = avg_new[21:16];

   always_comb begin
      if (32'(avg_bin) >= TABLE_DEPTH) begin
         tbl_raddr = TBL_AW'(TABLE_DEPTH - 1);
      end else begin
         tbl_raddr = TBL_AW'(avg_bin);
      end
   end

   assign tbl_rd_en = tick_accept;
   assign tbl_wr_en = req_accept && (op == OP_TABLE_WRITE) &&
                      (32'(req_data.table_index) < TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (tbl_wr_en) begin
         tbl_mem[TBL_AW'(req_data.table_index)] <= req_data.table_shift;
      end
      if (tbl_rd_en) begin
         tbl_rdata_ff <= tbl_mem[tbl_raddr];
      end
   end

   // ((rnd << 1) << shift) >> 16, low 16 bits
   assign thr_shifted = {32'h0, rnd_ff} << ({1'b0, tbl_rdata_ff} + 6'd1);
   assign table_thr   = thr_shifted[31:16];

   assign since_inc  = (since_ff == SINCE_MAX) ? since_ff : since_ff + 16'd1;
   assign red_kill   = (since_inc > thr_ff) && (since_inc > EARLY_MIN) &&
                       (pkt_cnt_ff >= {1'b0, cfg.min_threshold}) && cfg.red_enable;
   assign force_kill = (pkt_cnt_ff >= {1'b0, cfg.packet_limit}) ||
                       (byte_cnt_ff >= cfg.byte_limit);
   assign kill       = red_kill || force_kill;
   assign byte_sum   = {1'b0, byte_cnt_ff} + {9'd0, req_data.packet_length};

   always_comb begin
      lfsr_in      = lfsr_ff;
      rnd_in       = rnd_ff;
      avg_in       = avg_ff;
      since_in     = since_ff;
      thr_in       = thr_ff;
      pkt_cnt_in   = pkt_cnt_ff;
      byte_cnt_in  = byte_cnt_ff;
      drops_in     = drops_ff;
      forced_in    = forced_ff;
      arrivals_in  = arrivals_ff;
      sent_in      = sent_ff;
      resolve_in   = 1'b0;
      use_table_in = use_table_ff;
      drop_flag    = 1'b0;
      forced_flag  = 1'b0;
      empty_flag   = 1'b0;
      if (resolve_ff) begin
         thr_in = use_table_ff ? table_thr : MAXCOUNT_MAX;
      end else if (req_accept) begin
         case (op)
            OP_ARRIVAL: begin
               arrivals_in = arrivals_ff + 32'd1;
               forced_flag = force_kill;
               if (force_kill) begin
                  forced_in = forced_ff + 32'd1;
               end
               if (kill) begin
                  drop_flag = 1'b1;
                  drops_in  = drops_ff + 32'd1;
                  since_in  = 16'd0;
                  thr_in    = MAXCOUNT_MAX;
                  rnd_in    = lfsr_ff[15:0];
               end else begin
                  since_in    = since_inc;
                  pkt_cnt_in  = pkt_cnt_ff + 7'd1;
                  byte_cnt_in = byte_sum[24] ? BYTE_MAX : byte_sum[23:0];
               end
            end
            OP_DEPARTURE: begin
               if (pkt_cnt_ff == 7'd0) begin
                  empty_flag = 1'b1;
               end else begin
                  pkt_cnt_in  = pkt_cnt_ff - 7'd1;
                  byte_cnt_in = (byte_cnt_ff > {8'd0, req_data.packet_length}) ?
                                byte_cnt_ff - {8'd0, req_data.packet_length} : 24'd0;
                  sent_in     = sent_ff + 32'd1;
               end
            end
            OP_AVG_TICK: begin
               avg_in       = avg_new;
               use_table_in = avg_bin > cfg.min_threshold;
               resolve_in   = 1'b1;
            end
            OP_LFSR_TICK: begin
               lfsr_in = {lfsr_ff[7] ^ lfsr_ff[6] ^ lfsr_ff[2], lfsr_ff[31:1]};
            end
            default: ;
         endcase
      end
   end

   // a tick reports once the table entry is back
   assign push_valid = resolve_ff || (req_accept && (op != OP_AVG_TICK));

   always_comb begin
      push_data.drop          = drop_flag;
      push_data.forced        = forced_flag;
      push_data.empty_error   = empty_flag;
      push_data.queue_packets = pkt_cnt_in;
      push_data.queue_bytes   = byte_cnt_in;
      push_data.max_count     = thr_in;
      push_data.drop_total    = drops_in;
      push_data.forced_total  = forced_in;
      push_data.arrival_total = arrivals_in;
      push_data.sent_total    = sent_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff       <= LFSR_RESET;
         rnd_ff        <= RANDOM_RESET;
         avg_ff        <= 22'd0;
         since_ff      <= 16'd0;
         thr_ff        <= MAXCOUNT_MAX;
         pkt_cnt_ff    <= 7'd0;
         byte_cnt_ff   <= 24'd0;
         drops_ff      <= 32'd0;
         forced_ff     <= 32'd0;
         arrivals_ff   <= 32'd0;
         sent_ff       <= 32'd0;
         resolve_ff    <= 1'b0;
         use_table_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         lfsr_ff      <= lfsr_in;
         rnd_ff       <= rnd_in;
         avg_ff       <= avg_in;
         since_ff     <= since_in;
         thr_ff       <= thr_in;
         pkt_cnt_ff   <= pkt_cnt_in;
         byte_cnt_ff  <= byte_cnt_in;
         drops_ff     <= drops_in;
         forced_ff    <= forced_in;
         arrivals_ff  <= arrivals_in;
         sent_ff      <= sent_in;
         resolve_ff   <= resolve_in;
         use_table_ff <= use_table_in;
         // push only happens with the skid register empty
         if (skid_valid_ff) begin
            if (rsp_pop) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (push_valid) begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (push_valid) begin
         if (!out_valid_ff || rsp_pop) begin
            out_data_ff <= push_data;
         end else begin
            skid_data_ff <= push_data;
         end
      end
   end

   `RQDD_ASSERT(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff)
   `RQDD_ASSERT(a_resolve_skid_free, clock, reset, resolve_ff |-> !skid_valid_ff)
   `RQDD_ASSERT_NEXT(a_tick_resolves, clock, reset, tick_accept, resolve_ff && !req_accept)
   `RQDD_ASSERT_NEXT(a_resolve_single, clock, reset, resolve_ff, !resolve_ff)
   `RQDD_ASSERT(a_pkt_cnt_bound, clock, reset, !pkt_cnt_ff[6])

endmodule

// ===== hdl/rqdd_csr.sv =====
// configuration registers behind the apb-style port
module rqdd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rqdd_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready,
   output rqdd_pkg::cfg_type           cfg
);
   import rqdd_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red_enable    <= RST_RED_ENABLE;
         cfg_ff.min_threshold <= RST_MIN_THRESHOLD;
         cfg_ff.avg_weight    <= RST_AVG_WEIGHT;
         cfg_ff.packet_limit  <= RST_PACKET_LIMIT;
         cfg_ff.byte_limit    <= RST_BYTE_LIMIT;
      end else if (wr_en) begin
         unique case (reg_idx)
            CSR_RED_ENABLE:    cfg_ff.red_enable    <= csr_pwdata[0];
            CSR_MIN_THRESHOLD: cfg_ff.min_threshold <= csr_pwdata[5:0];
            CSR_AVG_WEIGHT:    cfg_ff.avg_weight    <= csr_pwdata[15:0];
            CSR_PACKET_LIMIT:  cfg_ff.packet_limit  <= csr_pwdata[5:0];
            CSR_BYTE_LIMIT:    cfg_ff.byte_limit    <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         CSR_RED_ENABLE:    csr_prdata = {31'd0, cfg_ff.red_enable};
         CSR_MIN_THRESHOLD: csr_prdata = {26'd0, cfg_ff.min_threshold};
         CSR_AVG_WEIGHT:    csr_prdata = {16'd0, cfg_ff.avg_weight};
         CSR_PACKET_LIMIT:  csr_prdata = {26'd0, cfg_ff.packet_limit};
         CSR_BYTE_LIMIT:    csr_prdata = {8'd0, cfg_ff.byte_limit};
         default:           csr_prdata = 32'd0;
      endcase
   end

endmodule

// ===== tb/tb_red_queue_drop_decider.sv =====
// testbench for the red queue drop decider: predicted results checked per transfer
module tb_red_queue_drop_decider;
   import rqdd_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PRINT_LIMIT   = 20;

   // codes with no defined operation
   localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   req_type             req_data    = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   rsp_type             rsp_data;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [31:0]         csr_pwdata  = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   // predicted block state
   cfg_type     csr_model;
   logic [31:0] prng_q;
   logic [15:0] rword_q;
   logic [21:0] avg_q;
   logic [15:0] since_q;
   logic [15:0] thresh_q;
   logic [6:0]  pkts_q;
   logic [23:0] bytes_q;
   logic [4:0]  shift_mem [TABLE_DEPTH];
   logic [31:0] drop_cnt;
   logic [31:0] forced_cnt;
   logic [31:0] arrival_cnt;
   logic [31:0] departure_cnt;

   rsp_type     awaited_results [$];
   int          n_requests       = 0;
   int          n_results        = 0;
   int          n_mismatches     = 0;
   int          empty_departures = 0;
   int          sender_idle_pct  = 0;
   int          rsp_stall_pct    = 0;
   int          stall_hold       = 0;
   bit          filling          = 1'b1;
   logic [6:0]  fill_target      = 7'd20;

   red_queue_drop_decider u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic req_type make_req(logic [2:0] op, logic [15:0] len,
                                        logic [5:0] idx, logic [4:0] sh);
      req_type r;
      r.operation     = op;
      r.packet_length = len;
      r.table_index   = idx;
      r.table_shift   = sh;
      return r;
   endfunction

   // applies one request to the predicted state and returns the result it gives
   function automatic rsp_type red_decide(req_type r);
      rsp_type     o;
      logic        kill;
      logic [24:0] sum;
      logic [63:0] w;
      logic [63:0] acc;
      logic [63:0] x;
      logic [5:0]  bin;
      logic [31:0] z;
      o = '0;
      case (r.operation)
         OP_ARRIVAL: begin
            arrival_cnt++;
            if (since_q < SINCE_MAX) since_q++;
            kill = (since_q > thresh_q) && (since_q > EARLY_MIN) &&
                   (pkts_q >= {1'b0, csr_model.min_threshold}) && csr_model.red_enable;
            if (pkts_q >= {1'b0, csr_model.packet_limit} || bytes_q >= csr_model.byte_limit) begin
               kill     = 1'b1;
               o.forced = 1'b1;
               forced_cnt++;
            end
            if (kill) begin
               o.drop   = 1'b1;
               drop_cnt++;
               since_q  = '0;
               thresh_q = MAXCOUNT_MAX;
               rword_q  = prng_q[15:0];
            end else begin
               pkts_q++;
               sum     = {1'b0, bytes_q} + {9'd0, r.packet_length};
               bytes_q = (sum > {1'b0, BYTE_MAX}) ? BYTE_MAX : sum[23:0];
            end
         end
         OP_DEPARTURE: begin
            if (pkts_q == '0) begin
               o.empty_error = 1'b1;
               empty_departures++;
            end else begin
               pkts_q--;
               bytes_q = (bytes_q > {8'd0, r.packet_length}) ?
                         bytes_q - {8'd0, r.packet_length} : '0;
               departure_cnt++;
            end
         end
         OP_AVG_TICK: begin
            w   = {48'd0, csr_model.avg_weight};
            x   = {57'd0, pkts_q};
            x   = x << 16;
            acc = (64'd65536 - w) * {42'd0, avg_q} + w * x;
            acc = acc >> 16;
            if (acc > {42'd0, AVG_MAX}) acc = {42'd0, AVG_MAX};
            avg_q = acc[21:0];
            bin   = avg_q[21:16];
            if (bin > csr_model.min_threshold) begin
               x        = {48'd0, rword_q};
               x        = (x << 1) << shift_mem[bin];
               thresh_q = x[31:16];
            end else begin
               thresh_q = MAXCOUNT_MAX;
            end
         end
         OP_LFSR_TICK: begin
            z      = prng_q >> 1;
            prng_q = {z[31] ^ z[6] ^ z[5] ^ z[1], z[30:0]};
         end
         OP_TABLE_WRITE: begin
            shift_mem[r.table_index] = r.table_shift;
         end
         default: begin
         end
      endcase
      o.queue_packets = pkts_q;
      o.queue_bytes   = bytes_q;
      o.max_count     = thresh_q;
      o.drop_total    = drop_cnt;
      o.forced_total  = forced_cnt;
      o.arrival_total = arrival_cnt;
      o.sent_total    = departure_cnt;
      return o;
   endfunction

   // fill and drain cycles keep the queue moving through its whole range
   function automatic req_type next_random_request();
      req_type r;
      int      pick;
      int      len_pick;
      int      arr_share;
      int      dep_share;
      if (filling && (pkts_q >= fill_target || $urandom_range(99) < 3)) begin
         filling = 1'b0;
      end else if (!filling && pkts_q == '0) begin
         filling     = 1'b1;
         fill_target = 7'($urandom_range(2, 63));
      end
      arr_share = filling ? 50 : 15;
      dep_share = filling ? 15 : 50;
      len_pick  = $urandom_range(99);
      if (len_pick < 10) r.packet_length = 16'($urandom_range(63));
      else if (len_pick < 80) r.packet_length = 16'($urandom_range(64, 1518));
      else r.packet_length = 16'($urandom_range(65535));
      r.table_index = 6'($urandom_range(63));
      r.table_shift = 5'($urandom_range(31));
      pick = $urandom_range(99);
      if (pick < arr_share) r.operation = OP_ARRIVAL;
      else if (pick < arr_share + dep_share) r.operation = OP_DEPARTURE;
      else if (pick < 83) r.operation = OP_AVG_TICK;
      else if (pick < 93) r.operation = OP_LFSR_TICK;
      else if (pick < 97) r.operation = OP_TABLE_WRITE;
      else r.operation = 3'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      n_mismatches++;
      if (n_mismatches <= PRINT_LIMIT)
         $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                  n_results, what, got, want);
   endtask

   // called at a falling edge; returns at a falling edge, with valid still high unless the sender idled
   task automatic send_request(req_type item);
      req_data  = item;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_results.push_back(red_decide(item));
      n_requests++;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write then read back one register
   task automatic csr_access(logic [2:0] idx, logic [31:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== value) report_mismatch("register read-back", csr_prdata, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_config(cfg_type c);
      wait_for_drain();
      csr_access(CSR_RED_ENABLE, {31'd0, c.red_enable});
      csr_access(CSR_MIN_THRESHOLD, {26'd0, c.min_threshold});
      csr_access(CSR_AVG_WEIGHT, {16'd0, c.avg_weight});
      csr_access(CSR_PACKET_LIMIT, {26'd0, c.packet_limit});
      csr_access(CSR_BYTE_LIMIT, {8'd0, c.byte_limit});
      csr_model = c;
   endtask

   function automatic cfg_type reset_config();
      cfg_type c;
      c.red_enable    = RST_RED_ENABLE;
      c.min_threshold = RST_MIN_THRESHOLD;
      c.avg_weight    = RST_AVG_WEIGHT;
      c.packet_limit  = RST_PACKET_LIMIT;
      c.byte_limit    = RST_BYTE_LIMIT;
      return c;
   endfunction

   // every entry gets written before an averaging tick can look it up
   task automatic test_table_load();
      logic [4:0] sh;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (i == 0) sh = 5'd0;
         else if (i == TABLE_DEPTH - 1) sh = 5'd31;
         else sh = 5'($urandom_range(31));
         send_request(make_req(OP_TABLE_WRITE, 16'($urandom_range(65535)), 6'(i), sh));
      end
      wait_for_drain();
   endtask

   task automatic test_directed_ops();
      for (int c = OP_UNKNOWN_LO; c <= OP_UNKNOWN_HI; c++)
         send_request(make_req(3'(c), 16'($urandom_range(65535)),
                               6'($urandom_range(63)), 5'($urandom_range(31))));
      send_request(make_req(OP_DEPARTURE, 16'hFFFF, 6'd0, 5'd0));   // empty queue
      send_request(make_req(OP_LFSR_TICK, 16'h0000, 6'h3F, 5'h1F));
      send_request(make_req(OP_ARRIVAL, 16'h0000, 6'd0, 5'd0));
      send_request(make_req(OP_ARRIVAL, 16'hFFFF, 6'h3F, 5'h1F));
      send_request(make_req(OP_ARRIVAL, 16'h0001, 6'd0, 5'd0));
      send_request(make_req(OP_DEPARTURE, 16'hFFFF, 6'd0, 5'd0));
      send_request(make_req(OP_DEPARTURE, 16'd200, 6'd0, 5'd0));     // byte underflow
      send_request(make_req(OP_AVG_TICK, 16'hFFFF, 6'h3F, 5'h1F));
      send_request(make_req(OP_TABLE_WRITE, 16'd0, 6'd63, 5'd31));
      send_request(make_req(OP_TABLE_WRITE, 16'hFFFF, 6'd0, 5'd0));
      send_request(make_req(OP_DEPARTURE, 16'd10, 6'd0, 5'd0));
      send_request(make_req(OP_DEPARTURE, 16'd10, 6'd0, 5'd0));
      wait_for_drain();
   endtask

   task automatic test_register_access();
      cfg_type c;
      c = '{red_enable: 1'b0, min_threshold: 6'd0, avg_weight: 16'd0,
            packet_limit: 6'd0, byte_limit: 24'd0};
      set_config(c);
      c = '{red_enable: 1'b1, min_threshold: 6'd63, avg_weight: 16'hFFFF,
            packet_limit: 6'd63, byte_limit: BYTE_MAX};
      set_config(c);
      set_config(reset_config());
   endtask

   task automatic test_zero_limits();
      cfg_type c;
      c = reset_config();
      c.packet_limit = 6'd0;
      set_config(c);
      repeat (3) send_request(make_req(OP_ARRIVAL, 16'd64, 6'd0, 5'd0));
      c.packet_limit = 6'd63;
      c.byte_limit   = 24'd0;
      set_config(c);
      repeat (2) send_request(make_req(OP_ARRIVAL, 16'd64, 6'd0, 5'd0));
      c.byte_limit = 24'd1;
      set_config(c);
      send_request(make_req(OP_ARRIVAL, 16'd5, 6'd0, 5'd0));
      send_request(make_req(OP_ARRIVAL, 16'd7, 6'd0, 5'd0));
      send_request(make_req(OP_DEPARTURE, 16'd5, 6'd0, 5'd0));
      send_request(make_req(OP_DEPARTURE, 16'd5, 6'd0, 5'd0));
      set_config(reset_config());
   endtask

   task automatic run_phase(logic red, logic [5:0] min_th, logic [15:0] weight,
                            logic [5:0] pkt_lim, logic [23:0] byte_lim,
                            int send_idle, int recv_stall, int count);
      cfg_type c;
      c = '{red_enable: red, min_threshold: min_th, avg_weight: weight,
            packet_limit: pkt_lim, byte_limit: byte_lim};
      set_config(c);
      sender_idle_pct = send_idle;
      rsp_stall_pct   = recv_stall;
      repeat (count) begin
         // now and then the sender waits for every outstanding result
         if ($urandom_range(59) == 0) wait_for_drain();
         send_request(next_random_request());
      end
      wait_for_drain();
   endtask

   task automatic test_random_traffic();
      run_phase(1'b1, 6'd5,  16'd131,   6'd63, 24'd96000,    0,  0,  95);
      run_phase(1'b1, 6'd0,  16'hFFFF,  6'd63, BYTE_MAX,    88,  0,  90);
      run_phase(1'b1, 6'd63, 16'd32768, 6'd63, 24'd200000,   0, 88,  90);
      run_phase(1'b0, 6'd2,  16'd4096,  6'd20, 24'd50000,    8,  8,  90);
      run_phase(1'b1, 6'd3,  16'hFFFF,  6'd63, BYTE_MAX,     0,  0, 100);
      run_phase(1'b1, 6'd1,  16'd0,     6'd40, 24'd1,       88,  0,  70);
      run_phase(1'b1, 6'd4,  16'd20000, 6'd1,  BYTE_MAX,     0, 88,  90);
      run_phase(1'b1, 6'd2,  16'd50000, 6'd63, 24'd300000,   8,  8,  95);
   endtask

   // receiver holds off while the sender keeps offering, so the block fills up
   task automatic test_receiver_hold_off();
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      stall_hold      = 200;
      repeat (40) send_request(next_random_request());
      wait_for_drain();
   endtask

   always @(negedge clock) begin
      if (stall_hold > 0) begin
         rsp_stall = 1'b1;
         stall_hold--;
      end else begin
         rsp_stall = ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("result with no request", 32'd0, 32'd0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_data.drop !== want.drop)
               report_mismatch("drop", {31'd0, rsp_data.drop}, {31'd0, want.drop});
            if (rsp_data.forced !== want.forced)
               report_mismatch("forced", {31'd0, rsp_data.forced}, {31'd0, want.forced});
            if (rsp_data.empty_error !== want.empty_error)
               report_mismatch("empty_error", {31'd0, rsp_data.empty_error},
                               {31'd0, want.empty_error});
            if (rsp_data.queue_packets !== want.queue_packets)
               report_mismatch("queue_packets", {25'd0, rsp_data.queue_packets},
                               {25'd0, want.queue_packets});
            if (rsp_data.queue_bytes !== want.queue_bytes)
               report_mismatch("queue_bytes", {8'd0, rsp_data.queue_bytes},
                               {8'd0, want.queue_bytes});
            if (rsp_data.max_count !== want.max_count)
               report_mismatch("max_count", {16'd0, rsp_data.max_count},
                               {16'd0, want.max_count});
            if (rsp_data.drop_total !== want.drop_total)
               report_mismatch("drop_total", rsp_data.drop_total, want.drop_total);
            if (rsp_data.forced_total !== want.forced_total)
               report_mismatch("forced_total", rsp_data.forced_total, want.forced_total);
            if (rsp_data.arrival_total !== want.arrival_total)
               report_mismatch("arrival_total", rsp_data.arrival_total, want.arrival_total);
            if (rsp_data.sent_total !== want.sent_total)
               report_mismatch("sent_total", rsp_data.sent_total, want.sent_total);
         end
         n_results++;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("run stopped after %0d cycles, %0d results still outstanding",
               CYCLE_LIMIT, awaited_results.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      csr_model     = reset_config();
      prng_q        = LFSR_RESET;
      rword_q       = RANDOM_RESET;
      avg_q         = '0;
      since_q       = '0;
      thresh_q      = MAXCOUNT_MAX;
      pkts_q        = '0;
      bytes_q       = '0;
      drop_cnt      = '0;
      forced_cnt    = '0;
      arrival_cnt   = '0;
      departure_cnt = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_table_load();
      test_directed_ops();
      test_register_access();
      test_zero_limits();
      test_random_traffic();
      test_receiver_hold_off();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d requests and %0d results checked over table load, directed ops,",
               n_requests, n_results);
      $display("zero limits, 8 traffic settings and a hold-off: %0d drops (%0d forced)",
               drop_cnt, forced_cnt);
      if (n_mismatches == 0 && awaited_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rqdd_pkg.sv
hdl/rqdd_csr.sv
hdl/red_queue_drop_decider.sv
tb/tb_red_queue_drop_decider.sv
